// File: rtl/isc_pkg.sv
// Shared types, codes and defaults for the interval set classifier.
package isc_pkg;

	localparam int DEF_TABLE_DEPTH  = 64;
	localparam int DEF_PATTERN_BITS = 64;
	localparam int LABEL_W          = 8;
	localparam int SLOT_W           = 6;
	localparam int WORD_BITS        = 64;

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_RELABEL  = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_RELABEL,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]           opcode;
		logic [SLOT_W-1:0]    entry_index;
		logic [WORD_BITS-1:0] lower_pattern;
		logic [WORD_BITS-1:0] upper_pattern;
		logic [LABEL_W-1:0]   entry_label;
		logic [LABEL_W-1:0]   replacement_label;
		logic [WORD_BITS-1:0] query_pattern;
	} in_word_t;

	typedef struct packed {
		logic [LABEL_W-1:0] result_label;
		logic               matched;
		logic [SLOT_W-1:0]  match_slot;
	} out_word_t;

	typedef struct packed {
		logic start;
		logic clr_sweep;
		logic scan;
		logic relabel;
		logic res_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic s1_last;
		logic hit_s1;
		logic out_free;
	} status_t;

endpackage

// File: rtl/isc_ctrl.sv
// Controller state machine of the interval set classifier.
module isc_ctrl
	import isc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_opcode,
	input  status_t    status,
	output logic       req_ready,
	output cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					case (op_t'(req_opcode))
						OP_CLASSIFY: state_d = ST_SCAN;
						OP_RELABEL:  state_d = ST_RELABEL;
						OP_CLEAR:    state_d = ST_CLEAR;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_RELABEL: begin
				if (status.s1_last) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (status.hit_s1 || status.s1_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				cmd.clr_sweep = 1'b1;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
			end
			ST_RELABEL: begin
				cmd.scan    = 1'b1;
				cmd.relabel = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan     = 1'b1;
				cmd.res_load = status.hit_s1 || status.s1_last;
			end
			ST_DONE: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/isc_datapath.sv
// Datapath of the interval set classifier: slot memories, scan counter and result registers.
module isc_datapath
	import isc_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int PATTERN_BITS = DEF_PATTERN_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  in_word_t           req,
	input  logic               rsp_ready,
	input  logic               cfg_we,
	input  logic [LABEL_W-1:0] cfg_wdata,
	input  cmd_t               cmd,
	output status_t            status,
	output logic               rsp_valid,
	output out_word_t          rsp
);

	localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

	logic                    valid_mem [TABLE_DEPTH];
	logic [LABEL_W-1:0]      label_mem [TABLE_DEPTH];
	logic [PATTERN_BITS-1:0] lower_mem [TABLE_DEPTH];
	logic [PATTERN_BITS-1:0] upper_mem [TABLE_DEPTH];

	logic [LABEL_W-1:0]      default_q;
	logic [LABEL_W-1:0]      lab_q;
	logic [LABEL_W-1:0]      newlab_q;
	logic [PATTERN_BITS-1:0] pattern_q;
	logic [CNT_W-1:0]        cnt_q;

	logic                    s1_valid_q;
	logic [ADDR_W-1:0]       addr_s1;
	logic                    vld_s1;
	logic [LABEL_W-1:0]      lab_s1;
	logic [PATTERN_BITS-1:0] lo_s1;
	logic [PATTERN_BITS-1:0] hi_s1;

	out_word_t               res_q;
	out_word_t               out_q;
	logic                    out_valid_q;

	logic              issue;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] ld_addr;
	logic              load_we;
	logic              relabel_we;
	logic              contains;
	logic              hit;

	assign rd_addr = cnt_q[ADDR_W-1:0];
	assign issue   = cmd.scan && (cnt_q != CNT_W'(TABLE_DEPTH));
	assign ld_addr = ADDR_W'(req.entry_index);
	assign load_we = cmd.start && (op_t'(req.opcode) == OP_LOAD)
		&& ({26'd0, req.entry_index} < 32'(TABLE_DEPTH));

	// pattern must carry every lower bit and nothing outside upper
	assign contains = ((pattern_q & lo_s1) == lo_s1) && ((pattern_q & ~hi_s1) == '0);
	assign hit      = s1_valid_q && vld_s1 && contains;
	assign relabel_we = cmd.relabel && s1_valid_q && vld_s1 && (lab_s1 == lab_q);

	assign status.clr_last = (cnt_q == CNT_W'(TABLE_DEPTH - 1));
	assign status.s1_last  = s1_valid_q && (addr_s1 == ADDR_W'(TABLE_DEPTH - 1));
	assign status.hit_s1   = hit;
	assign status.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (cfg_we) begin
			default_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lab_q     <= req.entry_label;
			newlab_q  <= req.replacement_label;
			pattern_q <= req.query_pattern[PATTERN_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= issue;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.clr_sweep || issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// valid memory: set by a load, dropped by the clearing sweep
	always_ff @(posedge clk) begin
		if (load_we) begin
			valid_mem[ld_addr] <= 1'b1;
		end else if (cmd.clr_sweep) begin
			valid_mem[rd_addr] <= 1'b0;
		end
		if (issue) begin
			vld_s1 <= valid_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			label_mem[ld_addr] <= req.entry_label;
		end else if (relabel_we) begin
			label_mem[addr_s1] <= newlab_q;
		end
		if (issue) begin
			lab_s1 <= label_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			lower_mem[ld_addr] <= req.lower_pattern[PATTERN_BITS-1:0];
			upper_mem[ld_addr] <= req.upper_pattern[PATTERN_BITS-1:0];
		end
		if (issue) begin
			lo_s1   <= lower_mem[rd_addr];
			hi_s1   <= upper_mem[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.result_label <= hit ? lab_s1 : default_q;
			res_q.matched      <= hit;
			res_q.match_slot   <= hit ? SLOT_W'(addr_s1) : '0;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// hold the result word until the far side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: rtl/interval_set_classifier_unit.sv
// Top level of the interval set classifier: controller and datapath joined.
// A load is written when it is accepted and leaves the block ready for the next word. A
// classify scans the slots from slot 0 up, one slot read a cycle from the slot memory, and
// stops at the first slot that holds the pattern; a hit, or a miss at the last slot, is
// stored in the result register and then passes to the output register. A relabel walks
// every slot through the same read port; a clear sweeps the valid memory. After reset a
// clearing pass runs before the first word is taken. A new word is taken while an earlier
// result still waits on the output register.
module interval_set_classifier_unit
	import isc_pkg::*;
#(
	parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
	parameter int PATTERN_BITS = DEF_PATTERN_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  in_word_t           req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output out_word_t          rsp,
	input  logic               cfg_we,
	input  logic [LABEL_W-1:0] cfg_wdata
);

	cmd_t    cmd;
	status_t status;

	isc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_opcode (req.opcode),
		.status     (status),
		.req_ready  (req_ready),
		.cmd        (cmd)
	);

	isc_datapath #(
		.TABLE_DEPTH  (TABLE_DEPTH),
		.PATTERN_BITS (PATTERN_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_ready (rsp_ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: rtl/isc_checker.sv
// Port-level checker for the interval set classifier, bound to the top level.
module isc_checker
	import isc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input in_word_t           req,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input out_word_t          rsp
);

	// a word that waits keeps its valid
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped before it was taken");

	// a word that waits keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("result word changed while stalled");

	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.matched |-> rsp.match_slot == '0)
		else $error("unmatched result carries a slot");

	// only a load leaves the block free for the next word at once
	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.opcode != OP_LOAD) |=> !req_ready)
		else $error("block free straight after a multi-cycle operation");

endmodule

bind interval_set_classifier_unit isc_checker u_isc_checker (.*);
